// ===== rtl/core/kta_pkg.sv =====
// Package for the keyword transposition alphabet block.
// Holds the word types, controller state, command/status groups and constants.
// No dependencies.
`timescale 1ns / 1ps

package kta_pkg;

  localparam int ALPHA_SIZE = 26;
  localparam int LETTER_W   = 5;
  // Column walk index: a column index plus one stride reaches 51 at most.
  localparam int IDX_W      = 6;

  localparam logic [LETTER_W-1:0] LETTER_END  = LETTER_W'(ALPHA_SIZE);
  localparam logic [LETTER_W-1:0] LETTER_LAST = LETTER_W'(ALPHA_SIZE - 1);

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                keyword_end;
  } in_word_t;

  typedef struct packed {
    logic [LETTER_W-1:0] alpha_letter;
    logic                alpha_last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCAN,
    ST_HEAD,
    ST_WALK,
    ST_WOUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic fill;
    logic scan;
    logic head;
    logic walk;
    logic wout;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic c_end;
    logic c_seen;
    logic fill_last;
    logic k_zero;
    logic walk_ok;
  } status_t;

endpackage

// ===== rtl/core/kta_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module kta_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 26
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/kta_ctrl.sv =====
// Sequencer for the keyword transposition alphabet block.
// Depends on kta_pkg for the state, command and status types.
`timescale 1ns / 1ps

module kta_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             keyword_end,
  input  kta_pkg::status_t status,
  output kta_pkg::cmd_t    cmd,
  output logic             busy
);

  import kta_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (keyword_end) begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (status.fill_last) begin
          state_nxt = status.k_zero ? ST_WALK : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.c_end) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (status.c_seen) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        cmd.head  = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk  = 1'b1;
        state_nxt = status.walk_ok ? ST_WOUT : ST_SCAN;
      end
      ST_WOUT: begin
        cmd.wout  = 1'b1;
        state_nxt = ST_WALK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/core/kta_dp.sv =====
// Datapath: letter set, column positions, spare-letter list and output word.
// Depends on kta_pkg and kta_ram.
`timescale 1ns / 1ps

module kta_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  kta_pkg::in_word_t  in_word,
  input  kta_pkg::cmd_t      cmd,
  output kta_pkg::status_t   status,
  output kta_pkg::out_word_t out_word,
  output logic               out_strobe
);

  import kta_pkg::*;

  logic [ALPHA_SIZE-1:0] mask_r, mask_nxt;
  logic [LETTER_W-1:0]   count_r, count_nxt;
  logic [LETTER_W-1:0]   c_r, c_nxt;
  logic [LETTER_W-1:0]   nspare_r, nspare_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [LETTER_W-1:0]   emit_cnt_r, emit_cnt_nxt;
  logic                  out_strobe_r;
  out_word_t             out_word_r;

  logic                  in_new;
  logic                  c_unused;
  logic [LETTER_W-1:0]   pos_rdata;
  logic [LETTER_W-1:0]   spare_rdata;
  logic [IDX_W-1:0]      stride;
  logic                  emit;

  // A letter in range that has not been taken yet opens a new column.
  assign in_new = (in_word.letter < LETTER_END) && !mask_r[in_word.letter];

  assign status.c_end     = (c_r >= LETTER_END);
  assign status.c_seen    = !status.c_end && mask_r[c_r];
  assign status.fill_last = (c_r == LETTER_LAST);
  assign status.k_zero    = (count_r == '0);
  assign status.walk_ok   = (idx_r < IDX_W'(nspare_r));

  assign c_unused = !status.c_end && !mask_r[c_r];
  // With no keyword the spare list is walked as one column.
  assign stride   = status.k_zero ? IDX_W'(1) : IDX_W'(count_r);
  assign emit     = cmd.head || cmd.wout;

  // Column index of each keyword letter, addressed by the letter.
  kta_ram #(.WIDTH(LETTER_W), .DEPTH(ALPHA_SIZE)) u_pos_ram (
    .clk   (clk),
    .we    (cmd.accept && in_new),
    .waddr (in_word.letter),
    .wdata (count_r),
    .re    (cmd.scan && status.c_seen),
    .raddr (c_r),
    .rdata (pos_rdata)
  );

  // Letters not in the keyword, in alphabetical order.
  kta_ram #(.WIDTH(LETTER_W), .DEPTH(ALPHA_SIZE)) u_spare_ram (
    .clk   (clk),
    .we    (cmd.fill && c_unused),
    .waddr (nspare_r),
    .wdata (c_r),
    .re    (cmd.walk && status.walk_ok),
    .raddr (idx_r[LETTER_W-1:0]),
    .rdata (spare_rdata)
  );

  // Next-state logic for the working registers.
  always_comb begin
    mask_nxt     = mask_r;
    count_nxt    = count_r;
    c_nxt        = c_r;
    nspare_nxt   = nspare_r;
    idx_nxt      = idx_r;
    emit_cnt_nxt = emit_cnt_r;

    if (cmd.accept) begin
      if (in_new) begin
        mask_nxt = mask_r | (ALPHA_SIZE'(1) << in_word.letter);
        if (count_r < LETTER_END) begin
          count_nxt = count_r + LETTER_W'(1);
        end
      end
      c_nxt        = '0;
      nspare_nxt   = '0;
      emit_cnt_nxt = '0;
    end

    if (cmd.fill) begin
      if (c_unused) begin
        nspare_nxt = nspare_r + LETTER_W'(1);
      end
      if (status.fill_last) begin
        // Plain alphabet skips the column scan entirely.
        c_nxt   = status.k_zero ? LETTER_END : '0;
        idx_nxt = '0;
      end else begin
        c_nxt = c_r + LETTER_W'(1);
      end
    end

    if (cmd.scan && !status.c_end && !status.c_seen) begin
      c_nxt = c_r + LETTER_W'(1);
    end

    if (cmd.head) begin
      idx_nxt = IDX_W'(pos_rdata);
    end

    if (cmd.walk && !status.walk_ok && !status.c_end) begin
      c_nxt = c_r + LETTER_W'(1);
    end

    if (cmd.wout) begin
      idx_nxt = idx_r + stride;
    end

    if (emit) begin
      emit_cnt_nxt = emit_cnt_r + LETTER_W'(1);
    end

    if (cmd.finish) begin
      mask_nxt  = '0;
      count_nxt = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r       <= '0;
      count_r      <= '0;
      c_r          <= '0;
      nspare_r     <= '0;
      idx_r        <= '0;
      emit_cnt_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      mask_r       <= mask_nxt;
      count_r      <= count_nxt;
      c_r          <= c_nxt;
      nspare_r     <= nspare_nxt;
      idx_r        <= idx_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      out_strobe_r <= emit;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r.alpha_letter <= cmd.head ? c_r : spare_rdata;
      out_word_r.alpha_last   <= (emit_cnt_r == LETTER_LAST);
    end
  end

  assign out_word   = out_word_r;
  assign out_strobe = out_strobe_r;

endmodule

// ===== rtl/core/keyword_transposition_alphabet_top.sv =====
// Top level of the keyword transposition alphabet block.
// Depends on kta_pkg, kta_ctrl, kta_dp and kta_ram.
`timescale 1ns / 1ps

// Keyword letters are taken one word per cycle while busy is low; a word is
// accepted at a clock edge with start high and busy low. A word with
// keyword_end set starts the alphabet build, and while busy is high 26 output
// words appear on out_word, each for one cycle with out_strobe high, alpha_last
// on the 26th. The receiver cannot stall the block and must take every word as
// it comes. The build is set by the sequencer: a sweep over the alphabet that
// writes the spare-letter RAM, then a pass over the alphabet that steps past
// each letter outside the keyword, emits each keyword letter followed by the
// spare letters of its column, and then finishes. With no keyword the sweep is
// followed by a walk of the whole spare list and a finish. Busy is still high
// when the last output word appears, so that word never shares a cycle with
// the next accepted word.

module keyword_transposition_alphabet_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  kta_pkg::in_word_t  in_word,
  output kta_pkg::out_word_t out_word,
  output logic               out_strobe
);

  import kta_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  kta_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .keyword_end (in_word.keyword_end),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy)
  );

  // Datapath.
  kta_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (cmd),
    .status     (status),
    .out_word   (out_word),
    .out_strobe (out_strobe)
  );

endmodule

// ===== sim/keyword_transposition_alphabet_top_tb.sv =====
// Self-checking testbench for the keyword transposition alphabet block.
// Predicts each 26-letter alphabet from the keyword words it sees accepted.
// Depends on kta_pkg and keyword_transposition_alphabet_top.
`timescale 1ns / 1ps

module keyword_transposition_alphabet_top_tb;
  import kta_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 120;
  localparam int IN_W = $bits(in_word_t);

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  out_word_t out_word;
  logic      out_strobe;

  // Predictor state: the keyword as the block should hold it.
  logic [ALPHA_SIZE-1:0] kw_seen;
  logic [LETTER_W-1:0]   kw_order [ALPHA_SIZE];
  int                    kw_count;

  out_word_t alphabet_q [$];
  int        errors;
  int        idle_pct;
  int        cycle_count;

  keyword_transposition_alphabet_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_word   (out_word),
    .out_strobe (out_strobe)
  );

  // Free-running clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("keyword_transposition_alphabet_top_tb failed");
      $finish;
    end
  end

  // Take one accepted keyword word into the predictor; on the end word,
  // queue the whole expected alphabet and clear the keyword.
  task automatic take_keyword_word(input in_word_t w);
    logic [LETTER_W-1:0] spare [ALPHA_SIZE];
    out_word_t           alpha [$];
    out_word_t           ow;
    int                  nspare;
    int                  col;
    int                  idx;
    nspare = 0;
    if (w.letter < ALPHA_SIZE && !kw_seen[w.letter]) begin
      kw_seen[w.letter] = 1'b1;
      kw_order[kw_count] = w.letter;
      kw_count++;
    end
    if (w.keyword_end) begin
      for (int c = 0; c < ALPHA_SIZE; c++) begin
        if (!kw_seen[c]) begin
          spare[nspare] = LETTER_W'(c);
          nspare++;
        end
      end
      if (kw_count == 0) begin
        // No keyword: the plain alphabet comes out.
        for (int c = 0; c < ALPHA_SIZE; c++) begin
          ow.alpha_letter = LETTER_W'(c);
          ow.alpha_last   = 1'b0;
          alpha.push_back(ow);
        end
      end else begin
        // Columns in alphabetical order of their heading letters.
        for (int c = 0; c < ALPHA_SIZE; c++) begin
          if (kw_seen[c]) begin
            col = 0;
            while (col < kw_count && kw_order[col] != LETTER_W'(c)) col++;
            ow.alpha_letter = LETTER_W'(c);
            ow.alpha_last   = 1'b0;
            alpha.push_back(ow);
            for (idx = col; idx < nspare; idx += kw_count) begin
              ow.alpha_letter = spare[idx];
              alpha.push_back(ow);
            end
          end
        end
      end
      if (alpha.size() > 0) alpha[alpha.size()-1].alpha_last = 1'b1;
      foreach (alpha[i]) alphabet_q.push_back(alpha[i]);
      kw_seen  = '0;
      kw_count = 0;
    end
  endtask

  // Check each output word against the oldest expectation, then predict from
  // the word accepted at this edge.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n) begin
      if (out_strobe) begin
        if (alphabet_q.size() == 0) begin
          $display("%0t: unexpected output word letter=%0d last=%0b", $time,
                   out_word.alpha_letter, out_word.alpha_last);
          errors++;
        end else begin
          exp_w = alphabet_q.pop_front();
          if (out_word.alpha_letter !== exp_w.alpha_letter) begin
            $display("%0t: alpha_letter expected %0d actual %0d", $time,
                     exp_w.alpha_letter, out_word.alpha_letter);
            errors++;
          end
          if (out_word.alpha_last !== exp_w.alpha_last) begin
            $display("%0t: alpha_last expected %0b actual %0b", $time,
                     exp_w.alpha_last, out_word.alpha_last);
            errors++;
          end
        end
      end
      if (start && !busy) take_keyword_word(in_word);
    end
  end

  // Send one keyword word, with an optional idle gap before it.
  task automatic send_keyword_word(input logic [LETTER_W-1:0] letter, input logic kend);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      start <= 1'b0;
      in_word <= IN_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_word <= '{letter: letter, keyword_end: kend};
    do @(posedge clk); while (busy);
  endtask

  // Hold the sender off until every expected output word has arrived.
  task automatic wait_alphabet_drained();
    @(negedge clk);
    start <= 1'b0;
    while (alphabet_q.size() != 0) @(posedge clk);
  endtask

  // Empty keyword: only out-of-range letters, each carrying the end mark.
  task automatic test_empty_keyword();
    send_keyword_word(5'd31, 1'b1);
    send_keyword_word(5'd26, 1'b1);
  endtask

  // Single letters at both ends of the alphabet, and the pair Z then A.
  task automatic test_edge_letters();
    send_keyword_word(5'd0, 1'b1);
    send_keyword_word(5'd25, 1'b1);
    send_keyword_word(5'd25, 1'b0);
    send_keyword_word(5'd0, 1'b1);
  endtask

  // Repeated letters are dropped; out-of-range letters are ignored, but one that
  // carries the end mark still ends the keyword.
  task automatic test_repeats_and_invalid();
    send_keyword_word(5'd1, 1'b0);
    send_keyword_word(5'd0, 1'b0);
    send_keyword_word(5'd27, 1'b0);
    send_keyword_word(5'd1, 1'b0);
    send_keyword_word(5'd31, 1'b0);
    send_keyword_word(5'd0, 1'b1);
    send_keyword_word(5'd2, 1'b0);
    send_keyword_word(5'd30, 1'b1);
  endtask

  // A keyword that uses all 26 letters leaves no spare letters.
  task automatic test_full_keyword();
    logic [LETTER_W-1:0] perm [ALPHA_SIZE];
    logic [LETTER_W-1:0] tmp;
    int                  j;
    for (int i = 0; i < ALPHA_SIZE; i++) perm[i] = LETTER_W'(i);
    for (int i = ALPHA_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < ALPHA_SIZE; i++) send_keyword_word(perm[i], i == ALPHA_SIZE - 1);
  endtask

  // Random keywords, mostly short, some long with many repeats, with a few
  // out-of-range letters and empty keywords mixed in.
  task automatic test_random_keywords(input int target, input int pct);
    int                  sent;
    int                  len;
    int                  r;
    logic [LETTER_W-1:0] l;
    logic                kend;
    idle_pct = pct;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_keyword_word(LETTER_W'(26 + $urandom_range(5)), 1'b1);
        sent++;
      end else begin
        if (r < 15) len = $urandom_range(11, 30);
        else len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 6) l = LETTER_W'(26 + $urandom_range(5));
          else l = LETTER_W'($urandom_range(25));
          kend = (i == len - 1);
          send_keyword_word(l, kend);
          sent++;
        end
      end
      if ($urandom_range(99) < 5) wait_alphabet_drained();
    end
    wait_alphabet_drained();
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_word     = '0;
    errors      = 0;
    idle_pct    = 0;
    cycle_count = 0;
    kw_seen     = '0;
    kw_count    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_keyword();
    test_edge_letters();
    test_repeats_and_invalid();
    wait_alphabet_drained();
    test_full_keyword();
    wait_alphabet_drained();

    test_random_keywords(120, 0);
    test_random_keywords(120, 60);
    test_random_keywords(120, 21);

    wait_alphabet_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && alphabet_q.size() == 0) begin
      $display("keyword_transposition_alphabet_top_tb passed");
    end else begin
      if (alphabet_q.size() != 0)
        $display("%0t: %0d expected words never arrived", $time, alphabet_q.size());
      $display("keyword_transposition_alphabet_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/kta_pkg.sv
rtl/core/kta_ram.sv
rtl/core/kta_ctrl.sv
rtl/core/kta_dp.sv
rtl/core/keyword_transposition_alphabet_top.sv
sim/keyword_transposition_alphabet_top_tb.sv
